// ----- rtl/core/rsc_pkg.sv -----
package rsc_pkg;

	localparam int RING_SLOTS  = 16;
	localparam int MAX_RESULTS = 32;
	localparam int ID_W        = 63;
	localparam int CNT_W       = 2;
	localparam int SLOT_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);
	localparam int IN_DATA_W   = 192;
	localparam int OUT_DATA_W  = 64;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef logic [ID_W-1:0] id_t;

	// One open ring: its two end nodes, the ways at both ends, segment count
	typedef struct packed {
		id_t              front_node;
		id_t              back_node;
		id_t              front_way;
		id_t              back_way;
		logic [CNT_W-1:0] cnt;
	} ring_t;

	// Write of one slot from the sequencer
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		ring_t             ring;
	} ring_wr_t;

endpackage

// ----- rtl/core/ring_segment_chainer_unit.sv -----
// Ring segment chainer. Each input item is one way segment of a relation
// (way id, first node, last node; tlast marks the last member). The item is
// matched against the open-ring table one slot per cycle, lowest slot first,
// using the single slot compare unit. An unmatched segment opens the
// lowest free slot, or is dropped with the overflow flag set when the
// table is full. After the last member the table is scanned once more, one
// slot per cycle while the output is not stalled, with an extra step for
// the back way of a closed ring of two, and the closing item is sent when
// the output is free. The way ids of closed rings of one or two segments
// are sent, at most MAX_RESULTS of them, and the scan stops once that
// many are found; an empty run yields one item with found low. tlast
// marks the last result item of a run, and the table and overflow flag
// are then cleared. The block takes no new item until the current one is
// fully processed.
module ring_segment_chainer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// way_id [62:0], first_node [125:63], last_node [188:126], zero [191:189]
	input  logic [rsc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// ring_way_id [62:0], zero [63]
	output logic [rsc_pkg::OUT_DATA_W-1:0]  m_tdata,
	// found [0], overflow [1]
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_EMIT,
		ST_FINISH
	} state_t;

	localparam logic [rsc_pkg::SLOT_W-1:0] LAST_SLOT = rsc_pkg::SLOT_W'(rsc_pkg::RING_SLOTS - 1);
	localparam logic [rsc_pkg::RES_W-1:0]  LAST_RES  = rsc_pkg::RES_W'(rsc_pkg::MAX_RESULTS - 1);

	state_t                          state_q;
	logic [rsc_pkg::SLOT_W-1:0]      idx_q;
	logic                            phase_q;
	logic [rsc_pkg::RES_W-1:0]       nres_q;
	rsc_pkg::id_t                    way_q, first_q, last_q;
	logic                            final_q;
	logic                            ovf_q;
	logic                            pend_q;
	rsc_pkg::id_t                    pend_way_q;
	logic                            out_valid_q, out_found_q, out_ovf_q, out_last_q;
	rsc_pkg::id_t                    out_way_q;

	rsc_pkg::ring_t                  rd_ring;
	logic [rsc_pkg::RING_SLOTS-1:0]  valid;
	rsc_pkg::ring_wr_t               wr;
	logic                            clear;

	logic                            m0, m1, m2, m3, hit;
	rsc_pkg::ring_t                  joined;
	logic                            free_any;
	logic [rsc_pkg::SLOT_W-1:0]      free_idx;
	logic                            out_free;
	logic                            out_load;
	logic                            qual, have_res;
	rsc_pkg::id_t                    res_way;

	rsc_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (idx_q),
		.wr      (wr),
		.clear   (clear),
		.rd_ring (rd_ring),
		.valid   (valid)
	);

	// Compare the segment ends against the slot under the scan
	assign m0  = (rd_ring.front_node == first_q);
	assign m1  = (rd_ring.front_node == last_q);
	assign m2  = (rd_ring.back_node == first_q);
	assign m3  = (rd_ring.back_node == last_q);
	assign hit = valid[idx_q] && (m0 || m1 || m2 || m3);

	// Build the extended ring in the order front/first, front/last, back/first, back/last
	always_comb begin
		joined = rd_ring;
		if (m0) begin
			joined.front_node = last_q;
			joined.front_way  = way_q;
		end else if (m1) begin
			joined.front_node = first_q;
			joined.front_way  = way_q;
		end else if (m2) begin
			joined.back_node = last_q;
			joined.back_way  = way_q;
		end else begin
			joined.back_node = first_q;
			joined.back_way  = way_q;
		end
		if (rd_ring.cnt != rsc_pkg::CNT_MAX) begin
			joined.cnt = rd_ring.cnt + rsc_pkg::CNT_W'(1);
		end
	end

	// Find the lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = rsc_pkg::RING_SLOTS - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				free_any = 1'b1;
				free_idx = rsc_pkg::SLOT_W'(i);
			end
		end
	end

	// Table write: join on a hit, open a new ring after a full miss
	always_comb begin
		wr = '0;
		if (state_q == ST_MATCH) begin
			if (hit) begin
				wr.en   = 1'b1;
				wr.idx  = idx_q;
				wr.ring = joined;
			end else if (idx_q == LAST_SLOT && free_any) begin
				wr.en              = 1'b1;
				wr.idx             = free_idx;
				wr.ring.front_node = first_q;
				wr.ring.back_node  = last_q;
				wr.ring.front_way  = way_q;
				wr.ring.back_way   = way_q;
				wr.ring.cnt        = rsc_pkg::CNT_W'(1);
			end
		end
	end

	// Result candidate of the current emit step
	assign out_free = !out_valid_q || m_tready;
	assign qual     = valid[idx_q] && (rd_ring.cnt <= rsc_pkg::CNT_W'(2)) &&
	                  (rd_ring.front_node == rd_ring.back_node);
	assign have_res = phase_q || qual;
	assign res_way  = phase_q ? rd_ring.back_way : rd_ring.front_way;
	assign clear    = (state_q == ST_FINISH) && out_free;

	// Load the output register when a held result moves out or the run closes
	assign out_load = ((state_q == ST_EMIT) && have_res && pend_q && out_free) ||
	                  ((state_q == ST_FINISH) && out_free);

	// Sequencer, held payload and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			phase_q     <= 1'b0;
			nres_q      <= '0;
			way_q       <= '0;
			first_q     <= '0;
			last_q      <= '0;
			final_q     <= 1'b0;
			ovf_q       <= 1'b0;
			pend_q      <= 1'b0;
			pend_way_q  <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_way_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						way_q   <= s_tdata[rsc_pkg::ID_W-1:0];
						first_q <= s_tdata[2*rsc_pkg::ID_W-1:rsc_pkg::ID_W];
						last_q  <= s_tdata[3*rsc_pkg::ID_W-1:2*rsc_pkg::ID_W];
						final_q <= s_tlast;
						idx_q   <= '0;
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					if (hit || idx_q == LAST_SLOT) begin
						if (!hit && !free_any) begin
							ovf_q <= 1'b1;
						end
						idx_q   <= '0;
						phase_q <= 1'b0;
						nres_q  <= '0;
						pend_q  <= 1'b0;
						state_q <= final_q ? ST_EMIT : ST_IDLE;
					end else begin
						idx_q <= idx_q + rsc_pkg::SLOT_W'(1);
					end
				end
				ST_EMIT: begin
					if (have_res) begin
						// Stall while the held result cannot move to the output
						if (!pend_q || out_free) begin
							if (pend_q) begin
								out_way_q   <= pend_way_q;
								out_found_q <= 1'b1;
								out_ovf_q   <= ovf_q;
								out_last_q  <= 1'b0;
							end
							pend_q     <= 1'b1;
							pend_way_q <= res_way;
							nres_q     <= nres_q + rsc_pkg::RES_W'(1);
							if (nres_q == LAST_RES) begin
								state_q <= ST_FINISH;
							end else if (!phase_q && rd_ring.cnt == rsc_pkg::CNT_W'(2)) begin
								phase_q <= 1'b1;
							end else begin
								phase_q <= 1'b0;
								if (idx_q == LAST_SLOT) begin
									state_q <= ST_FINISH;
								end else begin
									idx_q <= idx_q + rsc_pkg::SLOT_W'(1);
								end
							end
						end
					end else if (idx_q == LAST_SLOT) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + rsc_pkg::SLOT_W'(1);
					end
				end
				ST_FINISH: begin
					// Send the closing item, then clear the run
					if (out_free) begin
						out_way_q   <= pend_q ? pend_way_q : '0;
						out_found_q <= pend_q;
						out_ovf_q   <= ovf_q;
						out_last_q  <= 1'b1;
						pend_q      <= 1'b0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_way_q};
	assign m_tuser  = {out_ovf_q, out_found_q};
	assign m_tlast  = out_last_q;

endmodule

// ----- rtl/core/rsc_table.sv -----
module rsc_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [rsc_pkg::SLOT_W-1:0]         rd_idx,
	input  rsc_pkg::ring_wr_t                  wr,
	input  logic                               clear,
	output rsc_pkg::ring_t                     rd_ring,
	output logic [rsc_pkg::RING_SLOTS-1:0]     valid
);

	rsc_pkg::ring_t ring_q [rsc_pkg::RING_SLOTS];
	logic [rsc_pkg::RING_SLOTS-1:0] valid_q;

	// Mark slots in use; drop them all at the end of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	// Ring contents, written one slot at a time
	always_ff @(posedge clk) begin
		if (wr.en) begin
			ring_q[wr.idx] <= wr.ring;
		end
	end

	assign rd_ring = ring_q[rd_idx];
	assign valid   = valid_q;

endmodule

// ----- rtl/core/rsc_check.sv -----
module rsc_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [rsc_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [1:0]                      m_tuser,
	input logic                            m_tlast
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("stalled result item changed");

	// An item without a ring way only closes an empty run
	a_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0)
		else $error("empty result item is not a run end");

	// The block is not ready again in the cycle after it takes an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// Nothing follows the run end item without a new input
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("result item after run end");

endmodule

bind ring_segment_chainer_unit rsc_check u_rsc_check (.*);

// ----- tb/sv/ring_report_checker.sv -----
module ring_report_checker
	import rsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// way_id [62:0], first_node [125:63], last_node [188:126], zero [191:189]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// ring_way_id [62:0], zero [63]
	input  logic [OUT_DATA_W-1:0] m_tdata,
	// found [0], overflow [1]
	input  logic [1:0]            m_tuser,
	input  logic                  m_tlast,
	output int                    errors,
	output int                    pending
);

	typedef struct {
		id_t way;
		bit  found;
		bit  overflow;
		bit  run_end;
	} report_t;

	ring_t   open_ring [RING_SLOTS];
	bit      slot_busy [RING_SLOTS];
	bit      seg_dropped;
	report_t reports_due [$];

	// Empty every slot and forget any drop
	function automatic void drop_table();
		for (int s = 0; s < RING_SLOTS; s++) begin
			slot_busy[s] = 1'b0;
			open_ring[s] = '0;
		end
		seg_dropped = 1'b0;
	endfunction

	// Attach a segment to the lowest ring with a matching end, else open a slot
	function automatic void join_or_open(id_t way, id_t first, id_t last);
		bit placed;
		placed = 1'b0;
		for (int s = 0; s < RING_SLOTS; s++) begin
			if (!placed && slot_busy[s]) begin
				placed = 1'b1;
				if (open_ring[s].front_node == first) begin
					open_ring[s].front_node = last;
					open_ring[s].front_way  = way;
				end else if (open_ring[s].front_node == last) begin
					open_ring[s].front_node = first;
					open_ring[s].front_way  = way;
				end else if (open_ring[s].back_node == first) begin
					open_ring[s].back_node = last;
					open_ring[s].back_way  = way;
				end else if (open_ring[s].back_node == last) begin
					open_ring[s].back_node = first;
					open_ring[s].back_way  = way;
				end else begin
					placed = 1'b0;
				end
				if (placed && open_ring[s].cnt != CNT_MAX)
					open_ring[s].cnt = open_ring[s].cnt + 1'b1;
			end
		end
		for (int s = 0; s < RING_SLOTS; s++) begin
			if (!placed && !slot_busy[s]) begin
				placed                  = 1'b1;
				slot_busy[s]            = 1'b1;
				open_ring[s].front_node = first;
				open_ring[s].back_node  = last;
				open_ring[s].front_way  = way;
				open_ring[s].back_way   = way;
				open_ring[s].cnt        = CNT_W'(1);
			end
		end
		if (!placed)
			seg_dropped = 1'b1;
	endfunction

	function automatic void push_report(id_t way, bit found);
		report_t r;
		r.way      = way;
		r.found    = found;
		r.overflow = seg_dropped;
		r.run_end  = 1'b0;
		reports_due = {reports_due, r};
	endfunction

	// Queue the ways of closed small rings, mark the run end, clear the table
	function automatic void emit_closed_rings();
		int n;
		n = 0;
		for (int s = 0; s < RING_SLOTS; s++) begin
			if (slot_busy[s] && open_ring[s].cnt <= 2 &&
			    open_ring[s].front_node == open_ring[s].back_node) begin
				if (n < MAX_RESULTS) begin
					push_report(open_ring[s].front_way, 1'b1);
					n++;
				end
				if (open_ring[s].cnt == 2 && n < MAX_RESULTS) begin
					push_report(open_ring[s].back_way, 1'b1);
					n++;
				end
			end
		end
		if (n == 0)
			push_report('0, 1'b0);
		reports_due[reports_due.size() - 1].run_end = 1'b1;
		drop_table();
	endfunction

	// Predict on each accepted segment, compare each accepted result item
	always @(posedge clk or negedge arst_n) begin : watch
		report_t want;
		if (!arst_n) begin
			drop_table();
			reports_due.delete();
			errors = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				join_or_open(s_tdata[ID_W-1:0], s_tdata[2*ID_W-1:ID_W],
				             s_tdata[3*ID_W-1:2*ID_W]);
				if (s_tlast)
					emit_closed_rings();
			end
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$error("result item with none expected: ring_way_id %h",
					       m_tdata[ID_W-1:0]);
					errors++;
				end else begin
					want = reports_due.pop_front();
					if (m_tdata[ID_W-1:0] !== want.way) begin
						$error("ring_way_id: expected %h, actual %h",
						       want.way, m_tdata[ID_W-1:0]);
						errors++;
					end
					if (m_tuser[0] !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, m_tuser[0]);
						errors++;
					end
					if (m_tuser[1] !== want.overflow) begin
						$error("overflow: expected %0d, actual %0d",
						       want.overflow, m_tuser[1]);
						errors++;
					end
					if (m_tlast !== want.run_end) begin
						$error("end_of_run: expected %0d, actual %0d", want.run_end, m_tlast);
						errors++;
					end
				end
			end
		end
		pending = reports_due.size();
	end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
	import rsc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef enum {REL_MIXED, REL_CROWDED, REL_FULL} relation_kind_e;

	typedef struct {
		id_t way;
		id_t first;
		id_t last;
		bit  final_seg;
	} segment_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	int       errors;
	int       pending;
	int       cycle_count;
	bit       calm;
	bit       hold_go;
	segment_t relation [$];

	ring_segment_chainer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	ring_report_checker report_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ring_segment_chainer_unit: mismatch");
			$finish;
		end
	end

	function automatic id_t any_id();
		return id_t'({$urandom(), $urandom()});
	endfunction

	// Mostly random node ids, with the extremes now and then
	function automatic id_t pick_node();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return any_id();
		endcase
	endfunction

	function automatic void put(id_t way, id_t first, id_t last, bit fin);
		segment_t g;
		g.way       = way;
		g.first     = first;
		g.last      = last;
		g.final_seg = fin;
		relation = {relation, g};
	endfunction

	// Add a segment with a random way id, either orientation
	function automatic void add_seg(id_t a, id_t b);
		if ($urandom_range(0, 1))
			put(any_id(), b, a, 1'b0);
		else
			put(any_id(), a, b, 1'b0);
	endfunction

	// Build one relation of shuffled segments ending with its last member
	function automatic void build_relation(relation_kind_e kind);
		id_t      a, b, c;
		int       j;
		segment_t g;
		relation.delete();
		case (kind)
			REL_FULL: begin
				repeat (RING_SLOTS) begin
					a = any_id();
					b = any_id();
					add_seg(a, b);
					add_seg(b, a);
				end
			end
			REL_CROWDED: begin
				repeat ($urandom_range(RING_SLOTS + 1, RING_SLOTS + 4))
					add_seg(any_id(), any_id());
				repeat ($urandom_range(0, 2)) begin
					a = any_id();
					add_seg(a, a);
				end
			end
			default: begin
				repeat ($urandom_range(0, 4)) begin
					a = pick_node();
					b = pick_node();
					c = pick_node();
					case ($urandom_range(0, 3))
						0: add_seg(a, a);
						1: begin
							add_seg(a, b);
							add_seg(b, a);
						end
						2: begin
							add_seg(a, b);
							add_seg(b, c);
							add_seg(c, a);
						end
						default: begin
							add_seg(a, b);
							if ($urandom_range(0, 1))
								add_seg(b, c);
						end
					endcase
				end
				repeat ($urandom_range(0, 2))
					add_seg(pick_node(), pick_node());
			end
		endcase
		if (relation.size() == 0)
			add_seg(pick_node(), pick_node());
		for (int i = relation.size() - 1; i > 0; i--) begin
			j           = $urandom_range(0, i);
			g           = relation[i];
			relation[i] = relation[j];
			relation[j] = g;
		end
		relation[relation.size() - 1].final_seg = 1'b1;
	endfunction

	// Offer one item at a falling edge and hold it until accepted
	task automatic send_item(segment_t g);
		while (!calm && $urandom_range(0, 99) < 34) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, g.last, g.first, g.way};
		s_tlast  <= g.final_seg;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_relation();
		foreach (relation[i])
			send_item(relation[i]);
	endtask

	// Receiver: random stalls, one long hold-off, calm stretch
	initial begin
		bit held;
		held     = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= arst_n && (calm || $urandom_range(0, 99) >= 34);
		end
	end

	// Stimulus and verdict
	initial begin
		id_t            a, b, c, d, e, f;
		int             sent;
		int             rel_no;
		relation_kind_e kind;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		arst_n   = 1'b0;
		calm     = 1'b0;
		hold_go  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		a = any_id();
		b = any_id();
		c = any_id();
		d = any_id();
		e = any_id();
		f = any_id();
		relation.delete();
		// empty run from an open segment, zero way id
		put('0, '0, '1, 1'b1);
		// closed ring of one segment, largest way id
		put('1, a, a, 1'b1);
		// closed ring of two through a front join on the first node
		put(any_id(), a, b, 1'b0);
		put(any_id(), a, b, 1'b1);
		// front join on the last node, then a third segment saturates the count
		put(any_id(), a, b, 1'b0);
		put(any_id(), c, a, 1'b0);
		put(any_id(), b, c, 1'b1);
		// back joins on first and last node, a closed single in slot one
		put(any_id(), a, b, 1'b0);
		put(any_id(), b, c, 1'b0);
		put(any_id(), d, c, 1'b0);
		put(any_id(), e, e, 1'b1);
		// segment touching two rings joins the lower slot
		put(any_id(), a, b, 1'b0);
		put(any_id(), c, d, 1'b0);
		put(any_id(), b, c, 1'b0);
		put(any_id(), f, f, 1'b1);
		// closed ring of two on the extreme node ids
		put(any_id(), '0, '1, 1'b0);
		put(any_id(), '1, '0, 1'b1);
		send_relation();

		sent   = 0;
		rel_no = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= 120 && sent < 190);
			if (rel_no == 2)
				hold_go = 1'b1;
			if (rel_no == 4)
				kind = REL_FULL;
			else if ($urandom_range(0, 9) == 0)
				kind = REL_CROWDED;
			else
				kind = REL_MIXED;
			build_relation(kind);
			sent += relation.size();
			send_relation();
			rel_no++;
		end
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ring_segment_chainer_unit: match");
		else
			$display("ring_segment_chainer_unit: mismatch");
		$finish;
	end

endmodule
